>>> rtl/spsp_pkg.sv
// Shared types and constants for the shortest path unit.
package spsp_pkg;

    localparam int MAX_VERTICES = 64;

    localparam logic [30:0] INF_DIST = 31'h7FFF_FFFF;

    localparam logic [1:0] REG_VERTEX_COUNT  = 2'd0;
    localparam logic [1:0] REG_SOURCE_VERTEX = 2'd1;
    localparam logic [1:0] REG_TARGET_VERTEX = 2'd2;
    localparam logic [1:0] REG_UNDIRECTED    = 2'd3;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_REV,
        ST_CLEAR,
        ST_SEED,
        ST_EDGE_RD,
        ST_RELAX,
        ST_SCAN,
        ST_PICK,
        ST_RESULT,
        ST_OUT
    } spsp_state_t;

endpackage

>>> rtl/single_pair_shortest_path_unit.sv
// Top level of the single-pair shortest path (Dijkstra) unit.
//
// Edges load one per cycle into an edge memory while in_stall is low; an
// undirected edge also stores its reverse in ST_REV, since the memory has a
// single write port, and the input stalls meanwhile. After the transfer marked
// last_edge the unit runs Dijkstra under a small sequencer with one shared
// adder/comparator. It clears the distance memory for every active vertex,
// seeds the source, then for each settled vertex walks every stored edge
// (registered edge read in ST_EDGE_RD, target distance read in ST_RELAX, and
// the update in ST_PICK when the edge leaves the current vertex for an
// unsettled target) and scans every vertex for the nearest unsettled one
// (address in ST_SCAN, compare in ST_OUT). With the source outside
// vertex_count the search is skipped after the clear. The input stalls from
// the last edge until the result is transferred. Edges whose endpoints fall
// outside vertex_count, or that overflow the edge memory, are dropped and
// reported through edges_dropped.
module single_pair_shortest_path_unit
    import spsp_pkg::*;
#(
    parameter int MAX_EDGES    = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [5:0]  from_vertex,
    input  logic [5:0]  to_vertex,
    input  logic [15:0] edge_weight,
    input  logic        last_edge,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [30:0] path_length,
    output logic        reachable,
    output logic        edges_dropped
);

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int EW = $clog2(MAX_EDGES);
    localparam int VCW = $clog2(MAX_VERTICES + 1);
    localparam int ECW = $clog2(MAX_EDGES + 1);

    // Configuration registers
    logic [6:0] vertex_count_reg;
    logic [5:0] source_vertex_reg;
    logic [5:0] target_vertex_reg;
    logic       undirected_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg  <= 7'd64;
            source_vertex_reg <= 6'd0;
            target_vertex_reg <= 6'd0;
            undirected_reg    <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_VERTEX_COUNT:  vertex_count_reg  <= cfg_data[6:0];
                REG_SOURCE_VERTEX: source_vertex_reg <= cfg_data[5:0];
                REG_TARGET_VERTEX: target_vertex_reg <= cfg_data[5:0];
                REG_UNDIRECTED:    undirected_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Active vertex count, clamped to capacity
    logic [VCW-1:0] n_act;
    always_comb
    begin
        if (32'(vertex_count_reg) > 32'(MAX_VERTICES))
            n_act = VCW'(MAX_VERTICES);
        else
            n_act = VCW'(vertex_count_reg);
    end

    // Memories
    logic [27:0] edge_mem [MAX_EDGES];
    logic [31:0] dist_mem [MAX_VERTICES];

    // Control and datapath registers
    spsp_state_t state_reg, state_next;
    logic [ECW-1:0] edge_count_reg, edge_count_next;
    logic           drop_reg, drop_next;
    logic [MAX_VERTICES-1:0] done_reg, done_next;
    logic [ECW-1:0] eidx_reg, eidx_next;
    logic [VCW-1:0] vidx_reg, vidx_next;
    logic [VW-1:0]  cur_reg, cur_next;
    logic [31:0]    cur_dist_reg, cur_dist_next;
    logic [VW-1:0]  best_reg, best_next;
    logic [31:0]    best_d_reg, best_d_next;
    logic           best_ok_reg, best_ok_next;
    logic [27:0]    pend_reg, pend_next;
    logic           out_valid_reg, out_valid_next;
    logic [30:0]    len_reg, len_next;
    logic           reach_reg, reach_next;
    logic           dropped_reg, dropped_next;

    // Memory ports
    logic           ewr_en;
    logic [EW-1:0]  ewr_addr;
    logic [27:0]    ewr_data;
    logic [EW-1:0]  erd_addr;
    logic [27:0]    erd_q;
    logic           dwr_en;
    logic [VW-1:0]  dwr_addr;
    logic [31:0]    dwr_data;
    logic [VW-1:0]  drd_addr;
    logic [31:0]    drd_q;

    always_ff @(posedge clk)
    begin
        if (ewr_en)
            edge_mem[ewr_addr] <= ewr_data;
        erd_q <= edge_mem[erd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (dwr_en)
            dist_mem[dwr_addr] <= dwr_data;
        drd_q <= dist_mem[drd_addr];
    end

    // Shared adder/comparator
    logic [31:0] alu_a, alu_b, alu_cmp, alu_sum;
    logic        alu_lt;
    assign alu_sum = alu_a + alu_b;
    assign alu_lt  = alu_sum < alu_cmp;

    logic in_acc;
    assign in_acc   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_LOAD);

    logic [5:0]  e_a, e_b;
    logic [15:0] e_w;
    assign e_a = erd_q[27:22];
    assign e_b = erd_q[21:16];
    assign e_w = erd_q[15:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            edge_count_reg <= '0;
            drop_reg       <= 1'b0;
            done_reg       <= '0;
            eidx_reg       <= '0;
            vidx_reg       <= '0;
            best_ok_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            edge_count_reg <= edge_count_next;
            drop_reg       <= drop_next;
            done_reg       <= done_next;
            eidx_reg       <= eidx_next;
            vidx_reg       <= vidx_next;
            best_ok_reg    <= best_ok_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        cur_dist_reg <= cur_dist_next;
        best_reg     <= best_next;
        best_d_reg   <= best_d_next;
        pend_reg     <= pend_next;
        len_reg      <= len_next;
        reach_reg    <= reach_next;
        dropped_reg  <= dropped_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        edge_count_next = edge_count_reg;
        drop_next       = drop_reg;
        done_next       = done_reg;
        eidx_next       = eidx_reg;
        vidx_next       = vidx_reg;
        cur_next        = cur_reg;
        cur_dist_next   = cur_dist_reg;
        best_next       = best_reg;
        best_d_next     = best_d_reg;
        best_ok_next    = best_ok_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg;
        len_next        = len_reg;
        reach_next      = reach_reg;
        dropped_next    = dropped_reg;
        ewr_en   = 1'b0;
        ewr_addr = edge_count_reg[EW-1:0];
        ewr_data = pend_reg;
        erd_addr = eidx_reg[EW-1:0];
        dwr_en   = 1'b0;
        dwr_addr = vidx_reg[VW-1:0];
        dwr_data = {1'b0, INF_DIST};
        drd_addr = vidx_reg[VW-1:0];
        alu_a    = cur_dist_reg;
        alu_b    = 32'(e_w);
        alu_cmp  = drd_q;

        case (state_reg)
            ST_LOAD:
            begin
                if (in_acc)
                begin
                    pend_next = {to_vertex, from_vertex, edge_weight};
                    if (VCW'(from_vertex) >= n_act || VCW'(to_vertex) >= n_act)
                    begin
                        drop_next = 1'b1;
                        state_next = last_edge ? ST_CLEAR : ST_LOAD;
                    end
                    else
                    begin
                        if (edge_count_reg >= ECW'(MAX_EDGES))
                            drop_next = 1'b1;
                        else
                        begin
                            ewr_en = 1'b1;
                            ewr_data = {from_vertex, to_vertex, edge_weight};
                            edge_count_next = edge_count_reg + ECW'(1);
                        end
                        if (undirected_reg)
                            state_next = ST_REV;
                        else
                            state_next = last_edge ? ST_CLEAR : ST_LOAD;
                    end
                    // Hold the last flag in best_ok until the search starts
                    best_ok_next = last_edge;
                    vidx_next = '0;
                    done_next = '0;
                end
            end
            ST_REV:
            begin
                // Append the reverse direction stored in pend as {to, from, w}
                if (edge_count_reg >= ECW'(MAX_EDGES))
                    drop_next = 1'b1;
                else
                begin
                    ewr_en = 1'b1;
                    edge_count_next = edge_count_reg + ECW'(1);
                end
                state_next = best_ok_reg ? ST_CLEAR : ST_LOAD;
            end
            ST_CLEAR:
            begin
                if (vidx_reg >= n_act)
                begin
                    if (VCW'(source_vertex_reg) >= n_act)
                        state_next = ST_RESULT;
                    else
                        state_next = ST_SEED;
                end
                else
                begin
                    dwr_en = 1'b1;
                    vidx_next = vidx_reg + VCW'(1);
                end
            end
            ST_SEED:
            begin
                dwr_en = 1'b1;
                dwr_addr = source_vertex_reg[VW-1:0];
                dwr_data = '0;
                cur_next = source_vertex_reg[VW-1:0];
                cur_dist_next = '0;
                done_next[source_vertex_reg[VW-1:0]] = 1'b1;
                eidx_next = '0;
                state_next = ST_EDGE_RD;
            end
            ST_EDGE_RD:
            begin
                // Edge memory read issued at eidx; distance read follows
                if (eidx_reg >= edge_count_reg)
                begin
                    vidx_next = '0;
                    best_ok_next = 1'b0;
                    best_d_next = {1'b0, INF_DIST};
                    state_next = ST_SCAN;
                end
                else
                    state_next = ST_RELAX;
            end
            ST_RELAX:
            begin
                // erd_q valid; fetch target distance first
                drd_addr = e_b[VW-1:0];
                if (!(VW'(e_a) == cur_reg && VCW'(e_b) < n_act
                      && !done_reg[e_b[VW-1:0]]))
                begin
                    eidx_next = eidx_reg + ECW'(1);
                    state_next = ST_EDGE_RD;
                end
                else
                    state_next = ST_PICK;
            end
            ST_PICK:
            begin
                // drd_q holds dist[b]; erd_q still holds the edge
                if (alu_lt)
                begin
                    dwr_en = 1'b1;
                    dwr_addr = e_b[VW-1:0];
                    dwr_data = alu_sum;
                end
                eidx_next = eidx_reg + ECW'(1);
                state_next = ST_EDGE_RD;
            end
            ST_SCAN:
            begin
                // Address in vidx here; the compare follows in ST_OUT
                if (vidx_reg >= n_act)
                begin
                    if (best_ok_reg)
                    begin
                        cur_next = best_reg;
                        cur_dist_next = best_d_reg;
                        done_next[best_reg] = 1'b1;
                        eidx_next = '0;
                        state_next = ST_EDGE_RD;
                    end
                    else
                        state_next = ST_RESULT;
                end
                else
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                drd_addr = vidx_reg[VW-1:0];
                alu_a = drd_q;
                alu_b = '0;
                alu_cmp = best_d_reg;
                // drd_q is dist[vidx] read in ST_SCAN
                if (!done_reg[vidx_reg[VW-1:0]] && alu_lt)
                begin
                    best_d_next = drd_q;
                    best_next = vidx_reg[VW-1:0];
                    best_ok_next = 1'b1;
                end
                vidx_next = vidx_reg + VCW'(1);
                state_next = ST_SCAN;
            end
            ST_RESULT:
            begin
                // Read the target distance; drd_q then sets len_reg and out_valid_reg
                drd_addr = target_vertex_reg[VW-1:0];
                if (out_valid_reg)
                begin
                    if (!out_stall)
                    begin
                        out_valid_next = 1'b0;
                        edge_count_next = '0;
                        drop_next = 1'b0;
                        state_next = ST_LOAD;
                    end
                end
                else if (best_ok_reg)
                begin
                    if (VCW'(source_vertex_reg) >= n_act
                        || VCW'(target_vertex_reg) >= n_act
                        || drd_q[30:0] == INF_DIST)
                    begin
                        len_next = INF_DIST;
                        reach_next = 1'b0;
                    end
                    else
                    begin
                        len_next = drd_q[30:0];
                        reach_next = 1'b1;
                    end
                    dropped_next = drop_reg;
                    out_valid_next = 1'b1;
                end
                else
                    best_ok_next = 1'b1;
            end
            default: state_next = ST_LOAD;
        endcase
    end

    assign out_valid     = out_valid_reg;
    assign path_length   = len_reg;
    assign reachable     = reach_reg;
    assign edges_dropped = dropped_reg;

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        edge_count_reg <= ECW'(MAX_EDGES))
        else $error("edge count beyond capacity");
    a_out_reach: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !reach_reg |-> len_reg == INF_DIST)
        else $error("unreachable result with finite length");
    a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> state_reg == ST_RESULT)
        else $error("result outside result state");
    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> in_stall)
        else $error("input open while result pending");

endmodule

>>> sim/tb_single_pair_shortest_path_unit.sv
// Self-checking testbench for the single-pair shortest path unit.
module tb_single_pair_shortest_path_unit
    import spsp_pkg::*;
();

    localparam int VCAP      = 64;
    localparam int ECAP      = 256;
    // Watchdog limit, several times the longest search.
    localparam int IDLE_LIMIT = 300000;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [5:0]  from_vertex;
    logic [5:0]  to_vertex;
    logic [15:0] edge_weight;
    logic        last_edge;
    logic        out_valid;
    logic        out_stall;
    logic [30:0] path_length;
    logic        reachable;
    logic        edges_dropped;

    single_pair_shortest_path_unit dut (.*);

    typedef struct packed {
        logic [30:0] length;
        logic        hit;
        logic        dropped;
    } path_result_t;

    // Shadow copy of the unit: registers, edge store, drop flag.
    logic [6:0]  sh_vertex_count;
    logic [5:0]  sh_source;
    logic [5:0]  sh_target;
    logic        sh_undirected;
    logic [5:0]  sh_edge_from [ECAP];
    logic [5:0]  sh_edge_to   [ECAP];
    logic [15:0] sh_edge_w    [ECAP];
    int          sh_edge_count;
    logic        sh_dropped;

    path_result_t pending_paths[$];
    int           error_count;
    int           items_sent;
    int           idle_cycles = 0;
    bit           stall_quiet;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int active_count();
        return (sh_vertex_count > VCAP) ? VCAP : int'(sh_vertex_count);
    endfunction

    function automatic void store_edge(logic [5:0] a, logic [5:0] b, logic [15:0] w);
        if (sh_edge_count >= ECAP)
        begin
            sh_dropped = 1'b1;
            return;
        end
        sh_edge_from[sh_edge_count] = a;
        sh_edge_to[sh_edge_count]   = b;
        sh_edge_w[sh_edge_count]    = w;
        sh_edge_count++;
    endfunction

    // Dijkstra over the shadow store; stop once nothing unsettled is reachable.
    function automatic logic [31:0] shortest_distance(int n);
        logic [31:0] vdist [VCAP];
        bit          settled [VCAP];
        logic [31:0] best_d;
        logic [31:0] cand;
        int          v;
        int          best;
        for (int u = 0; u < n; u++)
        begin
            vdist[u]   = 32'(INF_DIST);
            settled[u] = 1'b0;
        end
        if (int'(sh_source) >= n)
            return 32'(INF_DIST);
        vdist[sh_source] = 0;
        v = sh_source;
        forever
        begin
            settled[v] = 1'b1;
            for (int e = 0; e < sh_edge_count; e++)
            begin
                if (int'(sh_edge_from[e]) != v || int'(sh_edge_to[e]) >= n)
                    continue;
                if (settled[sh_edge_to[e]])
                    continue;
                cand = vdist[v] + 32'(sh_edge_w[e]);
                if (vdist[sh_edge_to[e]] > cand)
                    vdist[sh_edge_to[e]] = cand;
            end
            best   = n;
            best_d = 32'(INF_DIST);
            for (int u = 0; u < n; u++)
                if (!settled[u] && vdist[u] < best_d)
                begin
                    best_d = vdist[u];
                    best   = u;
                end
            if (best >= n)
                break;
            v = best;
        end
        if (int'(sh_target) >= n)
            return 32'(INF_DIST);
        return vdist[sh_target];
    endfunction

    function automatic void predict_edge(logic [5:0] a, logic [5:0] b, logic [15:0] w,
                                         logic last);
        int           n;
        logic [31:0]  d;
        path_result_t r;
        n = active_count();
        if (int'(a) >= n || int'(b) >= n)
            sh_dropped = 1'b1;
        else
        begin
            store_edge(a, b, w);
            if (sh_undirected)
                store_edge(b, a, w);
        end
        if (!last)
            return;
        d         = shortest_distance(n);
        r.length  = d[30:0];
        r.hit     = (d != 32'(INF_DIST));
        r.dropped = sh_dropped;
        pending_paths = {pending_paths, r};
        sh_edge_count = 0;
        sh_dropped    = 1'b0;
    endfunction

    // Write one register; the shadow copy follows at the transfer edge.
    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_VERTEX_COUNT:  sh_vertex_count = value[6:0];
            REG_SOURCE_VERTEX: sh_source       = value[5:0];
            REG_TARGET_VERTEX: sh_target       = value[5:0];
            REG_UNDIRECTED:    sh_undirected   = value[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_graph(int n, int src, int tgt, bit und);
        write_reg(REG_VERTEX_COUNT, 32'(n));
        write_reg(REG_SOURCE_VERTEX, 32'(src));
        write_reg(REG_TARGET_VERTEX, 32'(tgt));
        write_reg(REG_UNDIRECTED, 32'(und));
    endtask

    function automatic int random_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Send one edge; hold the payload until the transfer, then predict.
    task automatic send_edge(logic [5:0] a, logic [5:0] b, logic [15:0] w, logic last);
        int gap;
        gap = random_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        from_vertex = a;
        to_vertex   = b;
        edge_weight = w;
        last_edge   = last;
        in_valid    = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        predict_edge(a, b, w, last);
        items_sent++;
    endtask

    // Drop valid, drain every expected result, then let the unit settle.
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_paths.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Drive the receiver stall: bursts of random stall, long holds, quiet stretches.
    initial
    begin
        int mode;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            mode = $urandom_range(0, 99);
            if (stall_quiet || mode < 60)
                out_stall = 1'b0;
            else if (mode < 95)
                out_stall = $urandom_range(0, 1);
            else
            begin
                out_stall = 1'b1;
                repeat ($urandom_range(10, 40)) @(negedge clk);
            end
        end
    end

    // Check each result transfer against the oldest expectation.
    always @(posedge clk)
    begin
        path_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_paths.size() == 0)
            begin
                $display("%0t: unexpected result length=%0d reachable=%0b dropped=%0b",
                         $time, path_length, reachable, edges_dropped);
                error_count++;
            end
            else
            begin
                want = pending_paths.pop_front();
                if (path_length !== want.length)
                begin
                    $display("%0t: path_length expected %0d actual %0d",
                             $time, want.length, path_length);
                    error_count++;
                end
                if (reachable !== want.hit)
                begin
                    $display("%0t: reachable expected %0b actual %0b",
                             $time, want.hit, reachable);
                    error_count++;
                end
                if (edges_dropped !== want.dropped)
                begin
                    $display("%0t: edges_dropped expected %0b actual %0b",
                             $time, want.dropped, edges_dropped);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: end the run when no transfer happens for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_single_pair_shortest_path_unit: errors");
            $finish;
        end
    end

    task automatic test_small_directed();
        set_graph(4, 0, 3, 1'b0);
        send_edge(6'd0, 6'd1, 16'd5, 1'b0);
        send_edge(6'd1, 6'd3, 16'd7, 1'b0);
        send_edge(6'd0, 6'd3, 16'd20, 1'b0);
        send_edge(6'd3, 6'd3, 16'd1, 1'b1);
        drain();
    endtask

    task automatic test_extremes();
        // Full vertex range, widest weight, self loop of weight zero.
        set_graph(64, 63, 0, 1'b1);
        send_edge(6'd63, 6'd0, 16'hFFFF, 1'b0);
        send_edge(6'd0, 6'd0, 16'd0, 1'b0);
        send_edge(6'd62, 6'd63, 16'hFFFF, 1'b1);
        drain();
        // Target unreachable, search ends early.
        set_graph(64, 0, 63, 1'b0);
        send_edge(6'd0, 6'd1, 16'd0, 1'b0);
        send_edge(6'd63, 6'd0, 16'd3, 1'b1);
        drain();
        // Source equals target.
        set_graph(1, 0, 0, 1'b0);
        send_edge(6'd0, 6'd0, 16'd9, 1'b1);
        drain();
    endtask

    task automatic test_out_of_range();
        set_graph(5, 0, 4, 1'b1);
        send_edge(6'd0, 6'd7, 16'd1, 1'b0);
        send_edge(6'd9, 6'd1, 16'd1, 1'b0);
        send_edge(6'd0, 6'd4, 16'd2, 1'b1);
        drain();
        set_graph(5, 10, 1, 1'b0);
        send_edge(6'd0, 6'd1, 16'd2, 1'b1);
        drain();
        set_graph(5, 0, 30, 1'b0);
        send_edge(6'd0, 6'd1, 16'd2, 1'b1);
        drain();
        // No vertices at all; then a count beyond capacity.
        set_graph(0, 0, 0, 1'b0);
        send_edge(6'd0, 6'd0, 16'd4, 1'b1);
        drain();
        set_graph(127, 2, 60, 1'b1);
        send_edge(6'd2, 6'd60, 16'd11, 1'b1);
        drain();
        set_graph(100, 0, 63, 1'b0);
        send_edge(6'd0, 6'd63, 16'd12, 1'b1);
        drain();
    endtask

    task automatic test_store_full();
        // One directed graph of a single entry, then a graph of undirected pairs: the
        // first 128 pairs fill the store exactly and the final pair is dropped.
        set_graph(64, 0, 63, 1'b0);
        send_edge(6'd0, 6'd1, 16'd3, 1'b0);
        drain();
        write_reg(REG_UNDIRECTED, 32'd1);
        for (int i = 0; i < 129; i++)
            send_edge(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                      16'($urandom), i == 128);
        drain();
    endtask

    task automatic test_random_graphs();
        int n;
        int edges;
        int p;
        logic [5:0] a;
        logic [5:0] b;
        while (items_sent < 450)
        begin
            p = $urandom_range(0, 99);
            if (p < 80)
                n = $urandom_range(1, 12);
            else if (p < 92)
                n = 64;
            else if (p < 96)
                n = 0;
            else
                n = $urandom_range(65, 127);
            set_graph(n, (n > 0 && $urandom_range(0, 9) != 0) ? $urandom_range(0, n - 1)
                                                            : $urandom_range(0, 63),
                      (n > 0 && $urandom_range(0, 9) != 0) ? $urandom_range(0, n - 1)
                                                            : $urandom_range(0, 63),
                      $urandom_range(0, 1));
            stall_quiet = ($urandom_range(0, 4) == 0);
            edges = $urandom_range(1, 14);
            for (int i = 0; i < edges; i++)
            begin
                if (n > 0 && $urandom_range(0, 9) != 0)
                begin
                    a = 6'($urandom_range(0, (n > VCAP ? VCAP : n) - 1));
                    b = 6'($urandom_range(0, (n > VCAP ? VCAP : n) - 1));
                end
                else
                begin
                    a = 6'($urandom);
                    b = 6'($urandom);
                end
                send_edge(a, b, ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                           : 16'($urandom_range(0, 50)),
                          i == edges - 1);
            end
            drain();
        end
        stall_quiet = 1'b0;
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = REG_VERTEX_COUNT;
        cfg_data        = '0;
        in_valid        = 1'b0;
        from_vertex     = '0;
        to_vertex       = '0;
        edge_weight     = '0;
        last_edge       = 1'b0;
        sh_vertex_count = 7'd64;
        sh_source       = '0;
        sh_target       = '0;
        sh_undirected   = 1'b0;
        sh_edge_count   = 0;
        sh_dropped      = 1'b0;
        error_count     = 0;
        items_sent      = 0;
        stall_quiet     = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_small_directed();
        test_extremes();
        test_out_of_range();
        test_store_full();
        test_random_graphs();

        drain();
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("tb_single_pair_shortest_path_unit: clean");
        else
            $display("tb_single_pair_shortest_path_unit: errors");
        $finish;
    end

endmodule

>>> files.f
rtl/spsp_pkg.sv
rtl/single_pair_shortest_path_unit.sv
sim/tb_single_pair_shortest_path_unit.sv
